// ===== rtl/rsa_key_pair_generator_unit_assert.svh =====
// Assertion macros for the top-level RTL file.
`ifndef RSA_KEY_PAIR_GENERATOR_UNIT_ASSERT_SVH
`define RSA_KEY_PAIR_GENERATOR_UNIT_ASSERT_SVH
// Same-cycle implication, checked out of reset.
`define RKG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rkg assertion failed");
// Next-cycle implication, checked out of reset.
`define RKG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rkg assertion failed");
`endif

// ===== rtl/rkg_pkg.sv =====
package rkg_pkg;

  localparam int MaxPairsDef = 64;
  localparam int InW         = 16;
  localparam int WordW       = 32;
  localparam int DvdW        = 64;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_P   = 2'd1,
    ST_BAD_Q   = 2'd2,
    ST_NO_EXP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WHO_P = 2'd0,
    WHO_Q = 2'd1,
    WHO_C = 2'd2
  } who_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PR_START,
    S_PR_LOOP,
    S_PR_WAIT,
    S_PR_TRUE,
    S_PR_FALSE,
    S_MUL_N,
    S_MUL_N_WAIT,
    S_MUL_T,
    S_MUL_T_WAIT,
    S_CAND,
    S_CAND_WAIT,
    S_NEXT_C,
    S_INV_MOD,
    S_INV_STEP,
    S_INV_CHK,
    S_INV_DIV,
    S_FINISH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             done;
    logic [DvdW-1:0]  quot;
    logic [WordW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] prod;
  } mul_rsp_t;

endpackage

// ===== rtl/rkg_div.sv =====
module rkg_div
  import rkg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DvdW-1:0]  dividend,
  input  logic [WordW-1:0] divisor,
  output div_rsp_t         rsp
);

  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0]  dvd_r, dvd_nxt;
  logic [WordW-1:0] rem_r, rem_nxt;
  logic [WordW-1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [WordW:0]   sh;
  logic [WordW:0]   diff;

  // Restoring division, one quotient bit per cycle
  always_comb begin
    sh       = {rem_r, dvd_r[DvdW-1]};
    diff     = sh - {1'b0, dvs_r};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[WordW]) begin
        rem_nxt = diff[WordW-1:0];
        dvd_nxt = {dvd_r[DvdW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[WordW-1:0];
        dvd_nxt = {dvd_r[DvdW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DvdW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/rkg_mul.sv =====
module rkg_mul
  import rkg_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [InW-1:0] op_a,
  input  logic [InW-1:0] op_b,
  output mul_rsp_t       rsp
);

  localparam int CntW = $clog2(InW + 1);

  logic [WordW-1:0] mc_r, mc_nxt;
  logic [InW-1:0]   mp_r, mp_nxt;
  logic [WordW-1:0] acc_r, acc_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  // Shift-add, one multiplier bit per cycle
  always_comb begin
    mc_nxt   = mc_r;
    mp_nxt   = mp_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mc_nxt   = {{(WordW-InW){1'b0}}, op_a};
      mp_nxt   = op_b;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt  = {mc_r[WordW-2:0], 1'b0};
      mp_nxt  = {1'b0, mp_r[InW-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(InW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mc_r  <= mc_nxt;
    mp_r  <= mp_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ===== rtl/rsa_key_pair_generator_unit.sv =====
// Run time is data dependent: each trial division runs a start, 64 bit steps in the divider
// and a result, each product a start, 16 steps in the shift-add multiplier and a result,
// plus per-step control.
// Throughput: one request at a time; the next is taken after its last result transfers.
// A request gives up to MAX_PAIRS results, or one error result.
// Reset: synchronous active-low rst_n returns the controller to idle, no request pending.
module rsa_key_pair_generator_unit
  import rkg_pkg::*;
#(
  parameter int MAX_PAIRS = MaxPairsDef
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [InW-1:0]   in_first_prime,
  input  logic [InW-1:0]   in_second_prime,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] out_modulus,
  output logic [WordW-1:0] out_public_exponent,
  output logic [WordW-1:0] out_private_exponent,
  output logic [1:0]       out_status,
  output logic             out_last
);

  `include "rsa_key_pair_generator_unit_assert.svh"

  localparam int CntW = $clog2(MAX_PAIRS + 1);
  localparam int FW   = WordW / 2 + 1;
  localparam int SqW  = WordW + 2;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  who_t   who_r, who_nxt;

  logic [InW-1:0]   p_r, p_nxt, q_r, q_nxt;
  logic [WordW-1:0] n_r, n_nxt, t_r, t_nxt, c_r, c_nxt, v_r, v_nxt;
  logic [FW-1:0]    f_r, f_nxt;
  logic [SqW-1:0]   sq_r, sq_nxt;
  logic [WordW-1:0] tm_r, tm_nxt, r_r, r_nxt;
  logic [DvdW-1:0]  k_r, k_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             pv_r, pv_nxt;
  logic [WordW-1:0] pe_r, pe_nxt, pd_r, pd_nxt;
  logic [WordW-1:0] on_r, on_nxt, oe_r, oe_nxt, od_r, od_nxt;
  status_t          ost_r, ost_nxt;
  logic             olast_r, olast_nxt;

  logic             div_start, mul_start;
  logic [DvdW-1:0]  div_dvd;
  logic [WordW-1:0] div_dvs;
  logic [InW-1:0]   mul_a, mul_b;
  div_rsp_t         div_rsp;
  mul_rsp_t         mul_rsp;
  logic [WordW:0]   rsum;
  logic [WordW:0]   rdif;

  rkg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .rsp      (div_rsp)
  );

  rkg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .rsp   (mul_rsp)
  );

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = (state_r == S_EMIT);
  assign out_modulus          = on_r;
  assign out_public_exponent  = oe_r;
  assign out_private_exponent = od_r;
  assign out_status           = ost_r;
  assign out_last             = olast_r;

  // Running residue of k modulo e
  assign rsum = {1'b0, r_r} + {1'b0, tm_r};
  assign rdif = rsum - {1'b0, c_r};

  // Sequence the search
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    who_nxt   = who_r;
    p_nxt     = p_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    c_nxt     = c_r;
    v_nxt     = v_r;
    f_nxt     = f_r;
    sq_nxt    = sq_r;
    tm_nxt    = tm_r;
    r_nxt     = r_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    pv_nxt    = pv_r;
    pe_nxt    = pe_r;
    pd_nxt    = pd_r;
    on_nxt    = on_r;
    oe_nxt    = oe_r;
    od_nxt    = od_r;
    ost_nxt   = ost_r;
    olast_nxt = olast_r;
    div_start = 1'b0;
    div_dvd   = {{(DvdW-WordW){1'b0}}, v_r};
    div_dvs   = {{(WordW-FW){1'b0}}, f_r};
    mul_start = 1'b0;
    mul_a     = p_r;
    mul_b     = q_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p_nxt     = in_first_prime;
          q_nxt     = in_second_prime;
          v_nxt     = {{(WordW-InW){1'b0}}, in_first_prime};
          who_nxt   = WHO_P;
          pv_nxt    = 1'b0;
          cnt_nxt   = '0;
          state_nxt = S_PR_START;
        end
      end
      S_PR_START: begin
        f_nxt  = FW'(2);
        sq_nxt = SqW'(4);
        if (v_r < WordW'(2)) state_nxt = S_PR_FALSE;
        else state_nxt = S_PR_LOOP;
      end
      S_PR_LOOP: begin
        if (sq_r > {2'b0, v_r}) begin
          state_nxt = S_PR_TRUE;
        end else begin
          div_start = 1'b1;
          state_nxt = S_PR_WAIT;
        end
      end
      S_PR_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            state_nxt = S_PR_FALSE;
          end else begin
            sq_nxt    = sq_r + SqW'({f_r, 1'b1});
            f_nxt     = f_r + 1'b1;
            state_nxt = S_PR_LOOP;
          end
        end
      end
      S_PR_TRUE: begin
        priority case (who_r)
          WHO_P: begin
            v_nxt     = {{(WordW-InW){1'b0}}, q_r};
            who_nxt   = WHO_Q;
            state_nxt = S_PR_START;
          end
          WHO_Q: begin
            if (p_r == q_r) begin
              on_nxt    = '0;
              oe_nxt    = '0;
              od_nxt    = '0;
              ost_nxt   = ST_BAD_Q;
              olast_nxt = 1'b1;
              ret_nxt   = S_IDLE;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_MUL_N;
            end
          end
          default: begin
            if (c_r == {{(WordW-InW){1'b0}}, p_r} || c_r == {{(WordW-InW){1'b0}}, q_r}) begin
              state_nxt = S_NEXT_C;
            end else begin
              div_start = 1'b1;
              div_dvd   = {{(DvdW-WordW){1'b0}}, t_r};
              div_dvs   = c_r;
              state_nxt = S_INV_MOD;
            end
          end
        endcase
      end
      S_PR_FALSE: begin
        if (who_r == WHO_C) begin
          state_nxt = S_NEXT_C;
        end else begin
          on_nxt    = '0;
          oe_nxt    = '0;
          od_nxt    = '0;
          ost_nxt   = (who_r == WHO_P) ? ST_BAD_P : ST_BAD_Q;
          olast_nxt = 1'b1;
          ret_nxt   = S_IDLE;
          state_nxt = S_EMIT;
        end
      end
      S_MUL_N: begin
        mul_start = 1'b1;
        state_nxt = S_MUL_N_WAIT;
      end
      S_MUL_N_WAIT: begin
        if (mul_rsp.done) begin
          n_nxt     = mul_rsp.prod;
          state_nxt = S_MUL_T;
        end
      end
      S_MUL_T: begin
        mul_start = 1'b1;
        mul_a     = p_r - 1'b1;
        mul_b     = q_r - 1'b1;
        state_nxt = S_MUL_T_WAIT;
      end
      S_MUL_T_WAIT: begin
        if (mul_rsp.done) begin
          t_nxt     = mul_rsp.prod;
          c_nxt     = WordW'(2);
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        if (c_r < t_r && cnt_r < CntW'(MAX_PAIRS)) begin
          div_start = 1'b1;
          div_dvd   = {{(DvdW-WordW){1'b0}}, t_r};
          div_dvs   = c_r;
          state_nxt = S_CAND_WAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CAND_WAIT: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            state_nxt = S_NEXT_C;
          end else begin
            v_nxt     = c_r;
            who_nxt   = WHO_C;
            state_nxt = S_PR_START;
          end
        end
      end
      S_NEXT_C: begin
        c_nxt     = c_r + 1'b1;
        state_nxt = S_CAND;
      end
      S_INV_MOD: begin
        if (div_rsp.done) begin
          tm_nxt    = div_rsp.rem;
          r_nxt     = WordW'(1);
          k_nxt     = DvdW'(1);
          state_nxt = S_INV_STEP;
        end
      end
      S_INV_STEP: begin
        // Advance k by t and keep its residue
        k_nxt     = k_r + {{(DvdW-WordW){1'b0}}, t_r};
        r_nxt     = rdif[WordW] ? rsum[WordW-1:0] : rdif[WordW-1:0];
        state_nxt = S_INV_CHK;
      end
      S_INV_CHK: begin
        if (r_r == '0) begin
          div_start = 1'b1;
          div_dvd   = k_r;
          div_dvs   = c_r;
          state_nxt = S_INV_DIV;
        end else begin
          state_nxt = S_INV_STEP;
        end
      end
      S_INV_DIV: begin
        if (div_rsp.done) begin
          // Hold one pair back so the final one can carry last
          pe_nxt  = c_r;
          pd_nxt  = div_rsp.quot[WordW-1:0];
          pv_nxt  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (pv_r) begin
            on_nxt    = n_r;
            oe_nxt    = pe_r;
            od_nxt    = pd_r;
            ost_nxt   = ST_OK;
            olast_nxt = 1'b0;
            ret_nxt   = S_NEXT_C;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_NEXT_C;
          end
        end
      end
      S_FINISH: begin
        on_nxt    = n_r;
        olast_nxt = 1'b1;
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
        if (pv_r) begin
          oe_nxt  = pe_r;
          od_nxt  = pd_r;
          ost_nxt = ST_OK;
        end else begin
          oe_nxt  = '0;
          od_nxt  = '0;
          ost_nxt = ST_NO_EXP;
        end
      end
      S_EMIT: begin
        if (!out_stall) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    q_r     <= q_nxt;
    n_r     <= n_nxt;
    t_r     <= t_nxt;
    c_r     <= c_nxt;
    v_r     <= v_nxt;
    f_r     <= f_nxt;
    sq_r    <= sq_nxt;
    tm_r    <= tm_nxt;
    r_r     <= r_nxt;
    k_r     <= k_nxt;
    pe_r    <= pe_nxt;
    pd_r    <= pd_nxt;
    on_r    <= on_nxt;
    oe_r    <= oe_nxt;
    od_r    <= od_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
    who_r   <= who_nxt;
    ret_r   <= ret_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
    end
  end

  `RKG_ASSERT_IMP(a_ok_has_exp, out_valid && out_status == ST_OK, out_public_exponent != '0)
  `RKG_ASSERT_IMP(a_err_is_last, out_valid && out_status != ST_OK, out_last)
  `RKG_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CntW'(MAX_PAIRS))
  `RKG_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

// ===== bench/rsa_key_pair_generator_unit_tb.sv =====
module rsa_key_pair_generator_unit_tb;
  import rkg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [InW-1:0] p;
    logic [InW-1:0] q;
  } request_t;

  typedef struct packed {
    logic [WordW-1:0] modulus;
    logic [WordW-1:0] pub_exp;
    logic [WordW-1:0] priv_exp;
    status_t          status;
    logic             last;
  } key_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [InW-1:0]   in_first_prime = '0;
  logic [InW-1:0]   in_second_prime = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WordW-1:0] out_modulus;
  logic [WordW-1:0] out_public_exponent;
  logic [WordW-1:0] out_private_exponent;
  logic [1:0]       out_status;
  logic             out_last;

  request_t    request_q[$];
  key_result_t key_q[$];
  int          send_idle = 0;
  int          recv_idle = 0;
  int          errors = 0;

  rsa_key_pair_generator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_prime      (in_first_prime),
    .in_second_prime     (in_second_prime),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_modulus         (out_modulus),
    .out_public_exponent (out_public_exponent),
    .out_private_exponent(out_private_exponent),
    .out_status          (out_status),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  // Trial division; 0 and 1 are not prime
  function automatic bit prime_check(input longint unsigned v);
    longint unsigned f;
    if (v < 2) return 1'b0;
    for (f = 2; f * f <= v; f++) begin
      if (v % f == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Private exponent (1 + m*t)/e for the smallest m >= 1 with e dividing 1 + m*t
  function automatic logic [WordW-1:0] mod_inverse(input longint unsigned e,
                                                   input longint unsigned t);
    longint unsigned k;
    longint unsigned m;
    k = 1;
    for (m = 1; m <= e; m++) begin
      k += t;
      if (k % e == 0) return WordW'(k / e);
    end
    return '0;
  endfunction

  // Expand one request into its expected key results
  task automatic predict_keys(input request_t r);
    logic [WordW-1:0] n;
    logic [WordW-1:0] t;
    logic [WordW-1:0] c;
    int               cnt;
    key_result_t      k;
    cnt = 0;
    if (!prime_check(r.p)) begin
      key_q.push_back('{'0, '0, '0, ST_BAD_P, 1'b1});
      return;
    end
    if (!prime_check(r.q) || r.p == r.q) begin
      key_q.push_back('{'0, '0, '0, ST_BAD_Q, 1'b1});
      return;
    end
    n = WordW'(r.p) * WordW'(r.q);
    t = (WordW'(r.p) - 1) * (WordW'(r.q) - 1);
    for (c = 2; c < t && cnt < MaxPairsDef; c++) begin
      if (t % c == 0) continue;
      if (!prime_check(c) || c == r.p || c == r.q) continue;
      key_q.push_back('{n, c, mod_inverse(c, t), ST_OK, 1'b0});
      cnt++;
    end
    if (cnt == 0) begin
      key_q.push_back('{n, '0, '0, ST_NO_EXP, 1'b1});
    end else begin
      k = key_q.pop_back();
      k.last = 1'b1;
      key_q.push_back(k);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Drive requests; hold the payload while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        request_t r;
        r = request_q.pop_front();
        in_first_prime  <= r.p;
        in_second_prime <= r.q;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Randomly stall the result channel
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_keys('{in_first_prime, in_second_prime});
    end
    if (rst_n && out_valid && !out_stall) begin
      if (key_q.size() == 0) begin
        report_mismatch("unexpected result", out_modulus, '0);
      end else begin
        key_result_t w;
        w = key_q.pop_front();
        if (out_modulus !== w.modulus) report_mismatch("modulus", out_modulus, w.modulus);
        if (out_public_exponent !== w.pub_exp)
          report_mismatch("public_exponent", out_public_exponent, w.pub_exp);
        if (out_private_exponent !== w.priv_exp)
          report_mismatch("private_exponent", out_private_exponent, w.priv_exp);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
      end
    end
  end

  function automatic logic [InW-1:0] rand_prime(input int hi);
    logic [InW-1:0] v;
    do v = InW'($urandom_range(hi, 2)); while (!prime_check(v));
    return v;
  endfunction

  // Mostly cheap requests: small prime pairs, bad candidates, a few large primes
  task automatic queue_random(input int count);
    request_t r;
    int       kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        r.p = rand_prime(13);
        do r.q = rand_prime(13); while (r.q == r.p && $urandom_range(9) != 0);
      end else if (kind < 70) begin
        r.p = InW'($urandom);
        r.q = InW'($urandom);
      end else if (kind < 85) begin
        r.p = rand_prime(65535);
        r.q = ($urandom_range(1) == 0) ? r.p : InW'($urandom_range(65535) | 1'b0) & ~16'h1;
      end else begin
        r.p = rand_prime(7);
        r.q = InW'($urandom_range(255));
      end
      request_q.push_back(r);
    end
  endtask

  task automatic drain;
    wait (request_q.size() == 0 && !in_valid);
    wait (key_q.size() == 0);
  endtask

  initial begin
    request_t directed[] = '{
      '{16'd0, 16'd0}, '{16'd1, 16'd3}, '{16'd4, 16'd5}, '{16'd3, 16'd1},
      '{16'd3, 16'd3}, '{16'd2, 16'd3}, '{16'd3, 16'd5}, '{16'd2, 16'd2},
      '{16'hFFFF, 16'hFFFF}, '{16'd65521, 16'd4}, '{16'd5, 16'd7},
      '{16'd13, 16'd11}, '{16'd65521, 16'd65519}, '{16'd2, 16'd65521},
      '{16'd65521, 16'd0}, '{16'd3, 16'd2}
    };
    foreach (directed[i]) request_q.push_back(directed[i]);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 13;
    recv_idle = 64;
    drain();
    queue_random(28);
    drain();
    send_idle = 64;
    recv_idle = 13;
    queue_random(28);
    drain();
    send_idle = 0;
    recv_idle = 0;
    queue_random(28);
    drain();
    repeat (200) @(posedge clk);

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin
    #400ms;
    $display("simulation failed");
    $finish;
  end

endmodule
